// ===== src/rrwl_pkg.sv =====
// Shared types and constants for the recursive reader-writer lock engine.
// Used by every module in src/; no dependencies of its own.
`timescale 1ns / 1ps

package rrwl_pkg;

  // Fixed widths of the item fields
  localparam int CMD_W      = 3;
  localparam int ID_IN_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int OUT_CNT_W  = 16;

  // Defaults for the top level parameters
  localparam int DEF_ID_BITS    = 8;
  localparam int DEF_COUNT_BITS = 16;

  // Lock commands
  typedef enum logic [CMD_W-1:0] {
    CMD_READ_REQ       = 3'd0,
    CMD_READ_REL       = 3'd1,
    CMD_WRITE_REQ      = 3'd2,
    CMD_WRITE_RETRY    = 3'd3,
    CMD_WRITE_WITHDRAW = 3'd4,
    CMD_WRITE_REL      = 3'd5
  } cmd_t;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_PENDING     = 3'd2,
    ST_NOT_OWNER   = 3'd3,
    ST_BAD_ORDER   = 3'd4
  } status_t;

  // One command item as held in the input register
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ID_IN_W-1:0] id;
    logic               may_wait;
  } cmd_item_t;

  // One result item
  typedef struct packed {
    status_t              status;
    logic                 wake_writer;
    logic                 wake_readers;
    logic                 gate_open;
    logic [OUT_CNT_W-1:0] read_count;
    logic [OUT_CNT_W-1:0] write_depth;
    logic [OUT_CNT_W-1:0] owner_read_depth;
    logic                 is_writer;
  } result_t;

endpackage

// ===== src/rrwl_in_stage.sv =====
// Input register of the lock engine: holds one command item.
// Depends on rrwl_pkg.
`timescale 1ns / 1ps

module rrwl_in_stage
  import rrwl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_IN_W-1:0]  requester_id,
  input  logic                may_wait,
  input  logic                advance,
  output logic                item_valid,
  output cmd_item_t           item
);

  // Full and the item cannot move on: hold
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.cmd      <= cmd;
      item.id       <= requester_id;
      item.may_wait <= may_wait;
    end
  end

endmodule

// ===== src/rrwl_lock_core.sv =====
// Lock state registers and the single-pass command decode that updates them.
// Depends on rrwl_pkg.
`timescale 1ns / 1ps

module rrwl_lock_core
  import rrwl_pkg::*;
#(
  parameter int ID_BITS    = DEF_ID_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  cmd_item_t item,
  output result_t   result
);

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  // Lock state
  logic [COUNT_BITS-1:0] shared_holds, shared_holds_next;
  logic [COUNT_BITS-1:0] write_holds, write_holds_next;
  logic [COUNT_BITS-1:0] writer_read_holds, writer_read_holds_next;
  logic [COUNT_BITS-1:0] writers_waiting, writers_waiting_next;
  logic [ID_BITS-1:0]    owner_id, owner_id_next;
  logic                  owner_valid, owner_valid_next;
  logic                  gate_open, gate_open_next;
  logic                  gate_needs_close, gate_needs_close_next;

  logic [ID_BITS+ID_IN_W-1:0] id_ext;
  logic [ID_BITS-1:0]         id;
  logic                       is_owner;
  logic                       take_write;
  status_t                    status;
  logic                       wake_w;
  logic                       wake_r;

  logic [COUNT_BITS+OUT_CNT_W-1:0] shared_ext, write_ext, wread_ext;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] floor_dec(input logic [COUNT_BITS-1:0] v);
    floor_dec = (v == '0) ? v : v - 1'b1;
  endfunction

  // Requester id cut or padded to ID_BITS
  assign id_ext   = {{ID_BITS{1'b0}}, item.id};
  assign id       = id_ext[ID_BITS-1:0];
  assign is_owner = owner_valid && (owner_id == id);

  // Command decode and next state
  always_comb begin
    shared_holds_next      = shared_holds;
    write_holds_next       = write_holds;
    writer_read_holds_next = writer_read_holds;
    writers_waiting_next   = writers_waiting;
    owner_id_next          = owner_id;
    owner_valid_next       = owner_valid;
    gate_open_next         = gate_open;
    gate_needs_close_next  = gate_needs_close;
    status                 = ST_OK;
    wake_w                 = 1'b0;
    wake_r                 = 1'b0;
    take_write             = 1'b0;

    unique case (item.cmd)
      CMD_READ_REQ: begin
        if (!owner_valid) begin
          shared_holds_next = sat_inc(shared_holds);
        end else if (is_owner) begin
          writer_read_holds_next = sat_inc(writer_read_holds);
        end else if (item.may_wait) begin
          status = ST_PENDING;
        end else begin
          status = ST_WOULD_BLOCK;
        end
      end
      CMD_READ_REL: begin
        if (!owner_valid) begin
          if (shared_holds != '0) begin
            shared_holds_next = shared_holds - 1'b1;
            // last reader out wakes a waiting writer
            wake_w = (writers_waiting != '0) && (shared_holds_next == '0);
          end else begin
            status = ST_NOT_OWNER;
          end
        end else if (is_owner && (writer_read_holds != '0)) begin
          writer_read_holds_next = writer_read_holds - 1'b1;
        end else begin
          status = ST_NOT_OWNER;
        end
      end
      CMD_WRITE_REQ: begin
        if ((shared_holds == '0) &&
            (((write_holds == '0) && ((writers_waiting == '0) || !item.may_wait)) ||
             is_owner)) begin
          take_write = 1'b1;
        end else if (item.may_wait) begin
          writers_waiting_next = sat_inc(writers_waiting);
          status = ST_PENDING;
        end else begin
          status = ST_WOULD_BLOCK;
        end
      end
      CMD_WRITE_RETRY: begin
        if ((shared_holds == '0) && ((write_holds == '0) || is_owner)) begin
          take_write = 1'b1;
          writers_waiting_next = floor_dec(writers_waiting);
        end else if (item.may_wait) begin
          status = ST_PENDING;
        end else begin
          // timed out: the writer gives up its place
          writers_waiting_next = floor_dec(writers_waiting);
          status = ST_WOULD_BLOCK;
        end
      end
      CMD_WRITE_WITHDRAW: begin
        writers_waiting_next = floor_dec(writers_waiting);
      end
      CMD_WRITE_REL: begin
        if (!is_owner) begin
          status = ST_NOT_OWNER;
        end else if ((write_holds <= COUNT_BITS'(1)) && (writer_read_holds != '0)) begin
          status = ST_BAD_ORDER;
        end else begin
          write_holds_next = floor_dec(write_holds);
          if (write_holds_next == '0) begin
            owner_valid_next = 1'b0;
            owner_id_next    = '0;
          end
          if (writers_waiting == '0) begin
            gate_open_next        = 1'b1;
            gate_needs_close_next = 1'b1;
            wake_r                = 1'b1;
          end else begin
            wake_w = 1'b1;
          end
        end
      end
      default: begin
        // unused codes leave everything as it is
      end
    endcase

    // Write grant: closes the reader gate the first time
    if (take_write) begin
      if (gate_needs_close) begin
        gate_needs_close_next = 1'b0;
        gate_open_next        = 1'b0;
      end
      write_holds_next = sat_inc(write_holds);
      owner_id_next    = id;
      owner_valid_next = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_holds      <= '0;
      write_holds       <= '0;
      writer_read_holds <= '0;
      writers_waiting   <= '0;
      owner_id          <= '0;
      owner_valid       <= 1'b0;
      gate_open         <= 1'b1;
      gate_needs_close  <= 1'b1;
    end else if (fire) begin
      shared_holds      <= shared_holds_next;
      write_holds       <= write_holds_next;
      writer_read_holds <= writer_read_holds_next;
      writers_waiting   <= writers_waiting_next;
      owner_id          <= owner_id_next;
      owner_valid       <= owner_valid_next;
      gate_open         <= gate_open_next;
      gate_needs_close  <= gate_needs_close_next;
    end
  end

  // Result as seen after this command
  assign shared_ext = {{OUT_CNT_W{1'b0}}, shared_holds_next};
  assign write_ext  = {{OUT_CNT_W{1'b0}}, write_holds_next};
  assign wread_ext  = {{OUT_CNT_W{1'b0}}, writer_read_holds_next};

  always_comb begin
    result.status           = status;
    result.wake_writer      = wake_w;
    result.wake_readers     = wake_r;
    result.gate_open        = gate_open_next;
    result.read_count       = shared_ext[OUT_CNT_W-1:0];
    result.write_depth      = write_ext[OUT_CNT_W-1:0];
    result.owner_read_depth = wread_ext[OUT_CNT_W-1:0];
    result.is_writer        = owner_valid_next && (owner_id_next == id);
  end

endmodule

// ===== src/rrwl_out_stage.sv =====
// Result register of the lock engine: holds one result item until taken.
// Depends on rrwl_pkg.
`timescale 1ns / 1ps

module rrwl_out_stage
  import rrwl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              result,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 advance,
  output logic [STATUS_W-1:0]  status,
  output logic                 wake_writer,
  output logic                 wake_readers,
  output logic                 reader_gate_open,
  output logic [OUT_CNT_W-1:0] read_count,
  output logic [OUT_CNT_W-1:0] write_depth,
  output logic [OUT_CNT_W-1:0] owner_read_depth,
  output logic                 requester_is_writer
);

  result_t held;

  // Room for a new item when empty or being taken
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      held <= result;
    end
  end

  assign status              = held.status;
  assign wake_writer         = held.wake_writer;
  assign wake_readers        = held.wake_readers;
  assign reader_gate_open    = held.gate_open;
  assign read_count          = held.read_count;
  assign write_depth         = held.write_depth;
  assign owner_read_depth    = held.owner_read_depth;
  assign requester_is_writer = held.is_writer;

endmodule

// ===== src/recursive_rw_lock_engine.sv =====
// Recursive reader-writer lock engine: top level.
// Uses rrwl_pkg, rrwl_in_stage, rrwl_lock_core and rrwl_out_stage.
//
// Usage
//   Command channel (in_valid / in_stall): cmd, requester_id, may_wait.
//   Result channel (out_valid / out_stall): one result item per command,
//   in command order, giving the status, wake pulses and the lock counters
//   as they stand after that command.
//   Order: a command taken into the input register moves into the result
//   register whenever that register has room, and is offered from there.
//   Throughput: one command per cycle while out_stall is low. The lock
//   state is read and updated in the single cycle in which an item moves
//   from the input register to the result register, so back-to-back
//   commands see each other's effect.
//   Stalls: while out_stall holds a result, the input register still takes
//   one more item; in_stall rises only once both registers are full.
//   Reset (rst, synchronous): both registers empty, counters zero, no
//   writer, reader gate open.
`timescale 1ns / 1ps

module recursive_rw_lock_engine
  import rrwl_pkg::*;
#(
  parameter int ID_BITS    = DEF_ID_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [ID_IN_W-1:0]   requester_id,
  input  logic                 may_wait,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic                 wake_writer,
  output logic                 wake_readers,
  output logic                 reader_gate_open,
  output logic [OUT_CNT_W-1:0] read_count,
  output logic [OUT_CNT_W-1:0] write_depth,
  output logic [OUT_CNT_W-1:0] owner_read_depth,
  output logic                 requester_is_writer
);

  logic      advance;
  logic      item_valid;
  cmd_item_t item;
  result_t   result;

  rrwl_in_stage u_in_stage (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .requester_id (requester_id),
    .may_wait     (may_wait),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  rrwl_lock_core #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_lock_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (item_valid && advance),
    .item   (item),
    .result (result)
  );

  rrwl_out_stage u_out_stage (
    .clk                 (clk),
    .rst                 (rst),
    .load                (item_valid),
    .result              (result),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .advance             (advance),
    .status              (status),
    .wake_writer         (wake_writer),
    .wake_readers        (wake_readers),
    .reader_gate_open    (reader_gate_open),
    .read_count          (read_count),
    .write_depth         (write_depth),
    .owner_read_depth    (owner_read_depth),
    .requester_is_writer (requester_is_writer)
  );

endmodule

// ===== tb/sv/rrwl_lock_checker.sv =====
// Result checker for the recursive reader-writer lock engine.
// Watches both channels, keeps its own copy of the lock state and compares
// every result item field by field. Depends on rrwl_pkg.
`timescale 1ns / 1ps

module rrwl_lock_checker
  import rrwl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [ID_IN_W-1:0]   requester_id,
  input  logic                 may_wait,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [STATUS_W-1:0]  status,
  input  logic                 wake_writer,
  input  logic                 wake_readers,
  input  logic                 reader_gate_open,
  input  logic [OUT_CNT_W-1:0] read_count,
  input  logic [OUT_CNT_W-1:0] write_depth,
  input  logic [OUT_CNT_W-1:0] owner_read_depth,
  input  logic                 requester_is_writer,
  output int                   fail_count,
  output int                   results_owed
);

  typedef logic [DEF_COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_TOP  = '1;
  localparam int     REPORT_CAP = 200;

  // Lock state as the engine should hold it
  count_t                 shared_cnt;
  count_t                 write_cnt;
  count_t                 owner_rd_cnt;
  count_t                 waiting_cnt;
  logic [DEF_ID_BITS-1:0] owner;
  logic                   owner_set;
  logic                   gate_q;
  logic                   gate_rearm;

  // Predicted result items, oldest first
  result_t owed_q[$];
  int      reported;

  initial begin
    fail_count   = 0;
    results_owed = 0;
    reported     = 0;
  end

  // Saturating step up, floored step down
  function automatic count_t bump(count_t v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic count_t drop(count_t v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // Write grant: first grant after a gate reopen closes the reader gate
  task automatic grab_write(input logic [DEF_ID_BITS-1:0] id);
    if (gate_rearm) begin
      gate_rearm = 1'b0;
      gate_q     = 1'b0;
    end
    write_cnt = bump(write_cnt);
    owner     = id;
    owner_set = 1'b1;
  endtask

  // Apply one command item to the lock state and work out its result
  task automatic predict_item(input logic [CMD_W-1:0] c, input logic [ID_IN_W-1:0] rid,
                              input logic w, output result_t r);
    logic [DEF_ID_BITS-1:0] id;
    logic                   owns;
    id   = rid[DEF_ID_BITS-1:0];
    owns = owner_set && owner == id;
    r        = '0;
    r.status = ST_OK;
    case (c)
      CMD_READ_REQ: begin
        if (!owner_set) shared_cnt = bump(shared_cnt);
        else if (owns) owner_rd_cnt = bump(owner_rd_cnt);
        else if (w) r.status = ST_PENDING;
        else r.status = ST_WOULD_BLOCK;
      end
      CMD_READ_REL: begin
        if (!owner_set && shared_cnt != '0) begin
          shared_cnt    = shared_cnt - 1'b1;
          r.wake_writer = (waiting_cnt != '0) && (shared_cnt == '0);
        end else if (owns && owner_rd_cnt != '0) begin
          owner_rd_cnt = owner_rd_cnt - 1'b1;
        end else begin
          r.status = ST_NOT_OWNER;
        end
      end
      CMD_WRITE_REQ: begin
        // free lock with no queued writers (try-only skips the queue) or own lock
        if (shared_cnt == '0 &&
            ((write_cnt == '0 && (waiting_cnt == '0 || !w)) || owns)) begin
          grab_write(id);
        end else if (w) begin
          waiting_cnt = bump(waiting_cnt);
          r.status    = ST_PENDING;
        end else begin
          r.status = ST_WOULD_BLOCK;
        end
      end
      CMD_WRITE_RETRY: begin
        if (shared_cnt == '0 && (write_cnt == '0 || owns)) begin
          grab_write(id);
          waiting_cnt = drop(waiting_cnt);
        end else if (w) begin
          r.status = ST_PENDING;
        end else begin
          // wait timed out: the writer leaves the queue
          waiting_cnt = drop(waiting_cnt);
          r.status    = ST_WOULD_BLOCK;
        end
      end
      CMD_WRITE_WITHDRAW: waiting_cnt = drop(waiting_cnt);
      CMD_WRITE_REL: begin
        if (!owns) begin
          r.status = ST_NOT_OWNER;
        end else if (write_cnt <= 1 && owner_rd_cnt != '0) begin
          r.status = ST_BAD_ORDER;
        end else begin
          write_cnt = drop(write_cnt);
          if (write_cnt == '0) begin
            owner_set = 1'b0;
            owner     = '0;
          end
          // hand on to a queued writer, else reopen the reader gate
          if (waiting_cnt == '0) begin
            gate_q         = 1'b1;
            gate_rearm     = 1'b1;
            r.wake_readers = 1'b1;
          end else begin
            r.wake_writer = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.gate_open        = gate_q;
    r.read_count       = OUT_CNT_W'(shared_cnt);
    r.write_depth      = OUT_CNT_W'(write_cnt);
    r.owner_read_depth = OUT_CNT_W'(owner_rd_cnt);
    r.is_writer        = owner_set && owner == id;
  endtask

  task automatic check_field(input string name, input logic [OUT_CNT_W-1:0] want,
                             input logic [OUT_CNT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (reported < REPORT_CAP) begin
        reported++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  // Channel monitor: results are checked before the same edge's command is
  // predicted; a command never yields its result at the edge it is taken
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      shared_cnt   = '0;
      write_cnt    = '0;
      owner_rd_cnt = '0;
      waiting_cnt  = '0;
      owner        = '0;
      owner_set    = 1'b0;
      gate_q       = 1'b1;
      gate_rearm   = 1'b1;
      owed_q.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (owed_q.size() == 0) begin
          fail_count++;
          if (reported < REPORT_CAP) begin
            reported++;
            $display("%0t: result item with none expected, expected nothing, actual status %0d",
                     $time, status);
          end
        end else begin
          want = owed_q.pop_front();
          check_field("status", OUT_CNT_W'(want.status), OUT_CNT_W'(status));
          check_field("wake_writer", OUT_CNT_W'(want.wake_writer), OUT_CNT_W'(wake_writer));
          check_field("wake_readers", OUT_CNT_W'(want.wake_readers), OUT_CNT_W'(wake_readers));
          check_field("reader_gate_open", OUT_CNT_W'(want.gate_open),
                      OUT_CNT_W'(reader_gate_open));
          check_field("read_count", want.read_count, read_count);
          check_field("write_depth", want.write_depth, write_depth);
          check_field("owner_read_depth", want.owner_read_depth, owner_read_depth);
          check_field("requester_is_writer", OUT_CNT_W'(want.is_writer),
                      OUT_CNT_W'(requester_is_writer));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        predict_item(cmd, requester_id, may_wait, want);
        owed_q.push_back(want);
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// ===== tb/sv/recursive_rw_lock_engine_tb.sv =====
// Testbench top for the recursive reader-writer lock engine.
// Drives directed, counter-fill and random lock commands with random idling;
// depends on rrwl_pkg, recursive_rw_lock_engine and rrwl_lock_checker.
`timescale 1ns / 1ps

module recursive_rw_lock_engine_tb;
  import rrwl_pkg::*;

  localparam int RAND_ITEMS = 1100;
  localparam int QUIET_TAIL = 150;
  // longest legal silence is an idle gap, a stall burst and the engine's delay
  localparam int WATCHDOG   = 1000;
  localparam int DRAIN_WAIT = 8;
  localparam int FILL_RUN   = 8;

  // Command codes outside the defined set, which the engine ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     cmd          = '0;
  logic [ID_IN_W-1:0]   requester_id = '0;
  logic                 may_wait     = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic                 wake_writer;
  logic                 wake_readers;
  logic                 reader_gate_open;
  logic [OUT_CNT_W-1:0] read_count;
  logic [OUT_CNT_W-1:0] write_depth;
  logic [OUT_CNT_W-1:0] owner_read_depth;
  logic                 requester_is_writer;
  int                   fail_count;
  int                   results_owed;

  logic                 idle_on      = 1'b1;
  int                   lock_items   = 0;
  int                   stall_left   = 0;
  int                   quiet_cycles = 0;
  logic [ID_IN_W-1:0]   id_pool [4];

  recursive_rw_lock_engine dut (.*);

  rrwl_lock_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side back-pressure in bursts
  always @(posedge clk) begin : rx_pace
    int nxt;
    nxt = (stall_left == 0) ? 0 : stall_left - 1;
    if (nxt == 0 && idle_on && $urandom_range(0, 7) == 0) nxt = $urandom_range(1, 10);
    stall_left = nxt;
    out_stall <= (nxt != 0);
  end

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Mostly a small pool so owners and requesters meet
  function automatic logic [ID_IN_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return ID_IN_W'($urandom);
    return id_pool[$urandom_range(0, 3)];
  endfunction

  // One command item, with an optional idle burst ahead of it
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [ID_IN_W-1:0] id,
                          input logic w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    requester_id <= id;
    may_wait     <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (c <= CMD_WRITE_REL) lock_items++;
  endtask

  task automatic send_many(input logic [CMD_W-1:0] c, input logic [ID_IN_W-1:0] id,
                           input logic w, input int n);
    repeat (n) send_cmd(c, id, w);
  endtask

  // One short well-formed sequence, or a little noise
  task automatic random_scene();
    int                 n;
    int                 k;
    logic [ID_IN_W-1:0] a;
    logic [ID_IN_W-1:0] b;
    logic [ID_IN_W-1:0] d;
    a = pick_id();
    b = pick_id();
    d = pick_id();
    n = $urandom_range(0, 3);
    k = $urandom_range(0, 3);
    case ($urandom_range(0, 9)) inside
      0, 1: begin
        // readers share the lock, then leave
        repeat (n + 1) send_cmd(CMD_READ_REQ, pick_id(), coin());
        repeat (n + 1) send_cmd(CMD_READ_REL, pick_id(), coin());
      end
      2, 3: begin
        // nested writer session with owner reads
        repeat (n + 1) send_cmd(CMD_WRITE_REQ, a, coin());
        repeat (k) send_cmd(CMD_READ_REQ, a, coin());
        repeat (k) send_cmd(CMD_READ_REL, a, coin());
        repeat (n + 1) send_cmd(CMD_WRITE_REL, a, coin());
      end
      4, 5: begin
        // writer queued behind a reader, then the lock handed writer to writer
        send_cmd(CMD_READ_REQ, b, 1'b1);
        send_cmd(CMD_WRITE_REQ, a, 1'b1);
        repeat (n) send_cmd(CMD_WRITE_RETRY, a, 1'b1);
        send_cmd(CMD_READ_REL, b, 1'b1);
        send_cmd(CMD_WRITE_RETRY, a, coin());
        send_cmd(CMD_WRITE_REQ, d, 1'b1);
        send_cmd(CMD_WRITE_REL, a, coin());
        send_cmd(CMD_WRITE_RETRY, d, coin());
        send_cmd(CMD_WRITE_REL, d, coin());
      end
      6: begin
        // waiter gives up
        send_cmd(CMD_WRITE_REQ, a, 1'b1);
        send_cmd(CMD_WRITE_WITHDRAW, a, coin());
        send_cmd(CMD_WRITE_REL, a, coin());
      end
      7: begin
        // releases in the wrong order, then the right one
        send_cmd(CMD_WRITE_REQ, a, 1'b0);
        send_cmd(CMD_READ_REQ, a, 1'b0);
        send_cmd(CMD_WRITE_REL, a, 1'b0);
        send_cmd(CMD_READ_REL, a, 1'b0);
        send_cmd(CMD_WRITE_REL, a, 1'b0);
      end
      default: begin
        // noise over every code and every id
        repeat (n + 1) send_cmd(CMD_W'($urandom_range(0, 7)), ID_IN_W'($urandom), coin());
      end
    endcase
  endtask

  initial begin : stimulus
    int                 base;
    logic [ID_IN_W-1:0] wa;
    logic [ID_IN_W-1:0] wb;
    for (int i = 0; i < 4; i++) id_pool[i] = ID_IN_W'($urandom_range(0, 255));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: sharing, queued writer, nesting, wrong owner, wrong order
    send_cmd(CMD_READ_REQ, 8'hFF, 1'b0);
    send_cmd(CMD_READ_REQ, 8'h00, 1'b0);
    send_cmd(CMD_WRITE_REQ, 8'h5A, 1'b0);
    send_cmd(CMD_WRITE_REQ, 8'h5A, 1'b1);
    send_cmd(CMD_READ_REL, 8'hFF, 1'b0);
    send_cmd(CMD_READ_REL, 8'h00, 1'b1);
    send_cmd(CMD_READ_REL, 8'h00, 1'b0);
    send_cmd(CMD_WRITE_RETRY, 8'h5A, 1'b1);
    send_cmd(CMD_WRITE_REQ, 8'h5A, 1'b0);
    send_cmd(CMD_READ_REQ, 8'h5A, 1'b0);
    send_cmd(CMD_READ_REQ, 8'hA5, 1'b1);
    send_cmd(CMD_READ_REQ, 8'hA5, 1'b0);
    send_cmd(CMD_WRITE_REL, 8'hA5, 1'b0);
    send_cmd(CMD_READ_REL, 8'hA5, 1'b0);
    send_cmd(CMD_WRITE_REL, 8'h5A, 1'b0);
    send_cmd(CMD_WRITE_REL, 8'h5A, 1'b0);
    send_cmd(CMD_READ_REL, 8'h5A, 1'b0);
    send_cmd(CMD_WRITE_REL, 8'h5A, 1'b1);
    // retry and withdraw with nobody queued, timed-out retry
    send_cmd(CMD_WRITE_RETRY, 8'h33, 1'b0);
    send_cmd(CMD_WRITE_REQ, 8'h77, 1'b1);
    send_cmd(CMD_WRITE_RETRY, 8'h77, 1'b0);
    send_cmd(CMD_WRITE_WITHDRAW, 8'hCC, 1'b1);
    send_cmd(CMD_WRITE_REL, 8'h33, 1'b0);
    send_cmd(CMD_SPARE_A, 8'h12, 1'b0);
    send_cmd(CMD_SPARE_B, 8'hED, 1'b1);

    // Long runs at full rate: reader and waiting-writer counts rise, then partly fall
    idle_on = 1'b0;
    wa = id_pool[0];
    wb = ~wa;
    send_many(CMD_READ_REQ, wa, 1'b0, FILL_RUN + 2);
    send_many(CMD_READ_REL, wb, 1'b0, FILL_RUN);
    send_many(CMD_WRITE_REQ, wa, 1'b0, FILL_RUN + 2);
    send_many(CMD_READ_REQ, wa, 1'b0, FILL_RUN + 2);
    send_many(CMD_WRITE_REQ, wb, 1'b1, FILL_RUN + 2);
    send_many(CMD_WRITE_WITHDRAW, wb, 1'b0, FILL_RUN + 1);
    send_many(CMD_READ_REL, wa, 1'b0, FILL_RUN);
    send_many(CMD_WRITE_REL, wa, 1'b0, FILL_RUN);

    // Random sequences; idling stops for the last stretch
    base = lock_items;
    while (lock_items - base < RAND_ITEMS) begin
      idle_on = (RAND_ITEMS - (lock_items - base) > QUIET_TAIL) && ($urandom_range(0, 5) != 0);
      random_scene();
    end

    // Drain and give the verdict
    idle_on = 1'b0;
    in_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
